### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// every macro expects clk and arst_n in scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked at every edge outside reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/u8d_pkg.sv
// types, codes and constants of the utf-8 to utf-32 decoder
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package u8d_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEFT_W   = 3;
	localparam int CP_W     = 21;
	localparam int CHARS_W  = 16;
	localparam int CAP_W    = 16;
	localparam int REG_IDX_W = 2;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_TWO   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
	localparam logic [CP_W-1:0] MIN_FOUR  = 21'h010000;

	localparam logic [CHARS_W-1:0] CHARS_MAX = '1;
	localparam logic [CAP_W-1:0]   CAP_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_TRUNCATED = 3'd2,
		ST_BAD_CONT  = 3'd3,
		ST_OVERLONG  = 3'd4,
		ST_SURROGATE = 3'd5,
		ST_CAPACITY  = 3'd6
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ALLOW_OVERLONG  = 2'd0,
		REG_ALLOW_SURROGATE = 2'd1,
		REG_CAPACITY_CHECK  = 2'd2,
		REG_CAPACITY        = 2'd3
	} reg_idx_t;

endpackage

`default_nettype wire

### rtl/u8d_ifs.sv
// valid/ready channel interfaces of the decoder: byte input, result output, register writes
// depends on u8d_pkg
`default_nettype none

interface u8d_in_if import u8d_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;
	logic [LEFT_W-1:0] bytes_left;

	modport source (output valid, output byte_value, output bytes_left, input ready);
	modport sink   (input valid, input byte_value, input bytes_left, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*;;
	logic               valid;
	logic               ready;
	logic               has_codepoint;
	logic [CP_W-1:0]    codepoint;
	logic [2:0]         status;
	logic               sequence_done;
	logic [CHARS_W-1:0] chars_done;

	modport source (output valid, output has_codepoint, output codepoint, output status,
		output sequence_done, output chars_done, input ready);
	modport sink   (input valid, input has_codepoint, input codepoint, input status,
		input sequence_done, input chars_done, output ready);
endinterface

interface u8d_cfg_if import u8d_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CAP_W-1:0]     wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/utf8_to_utf32_decoder.sv
// top level of the utf-8 to utf-32 stream decoder
// depends on u8d_pkg, u8d_ifs.sv (channel interfaces) and assert_macros.svh
//
//  channel  | dir | payload                                       | ready
//  ---------+-----+-----------------------------------------------+--------------------------
//  in_ch    | in  | byte_value[7:0], bytes_left[2:0]              | input stage free/moving
//  out_ch   | out | has_codepoint, codepoint[20:0], status[2:0],  | driven by consumer
//           |     | sequence_done, chars_done[15:0]               |
//  cfg_ch   | in  | reg_index[1:0], wdata[15:0]                   | always high
//
// one byte per clock sustained while out_ch is ready; a byte's transfer loads the input register,
// and whenever the result register can take it, the decode logic runs from there into the result
// register, which drives out_ch
// the decode state (pending continuation bytes, partial code point, char count) is updated
// in the same cycle that the byte leaves the input register, so consecutive bytes chain freely
// a stalled result register holds the input stage; the input register still takes one more
// byte, so in_ch only drops ready when both stages are full
// reset clears all control state and the registers to their defaults (capacity 65535)
`default_nettype none

module utf8_to_utf32_decoder
	import u8d_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	u8d_in_if.sink     in_ch,
	u8d_out_if.source  out_ch,
	u8d_cfg_if.sink    cfg_ch
);

`include "assert_macros.svh"

	// width wide enough for both the char counter and 16-bit compares
	localparam int CXW = (COUNT_WIDTH > CHARS_W) ? COUNT_WIDTH : CHARS_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// configuration registers
	logic             allow_overlong_q;
	logic             allow_surrogate_q;
	logic             capacity_check_q;
	logic [CAP_W-1:0] capacity_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [LEFT_W-1:0] left_s1;

	// decode state
	logic [1:0]             btc_q;      // continuation bytes still expected
	logic [2:0]             len_q;      // length of the character in progress
	logic [CP_W-1:0]        partial_q;  // code point bits gathered so far
	logic [COUNT_WIDTH-1:0] count_q;    // characters completed in this sequence
	logic                   skip_q;     // swallowing the rest of a failed sequence

	// result register
	logic               res_valid_q;
	logic               res_has_cp_q;
	logic [CP_W-1:0]    res_cp_q;
	status_t            res_status_q;
	logic               res_done_q;
	logic [CHARS_W-1:0] res_chars_q;

	// decode logic
	logic [2:0]             left_n;
	logic                   last;
	logic [2:0]             lead_len;
	logic [CP_W-1:0]        lead_cp;
	logic                   cap_full;
	status_t                status;
	logic                   complete;
	logic [1:0]             btc_new;
	logic [1:0]             btc_dec;
	logic [2:0]             len_new;
	logic [CP_W-1:0]        cp_new;
	logic [CP_W-1:0]        cont_bits;
	logic                   overlong;
	logic                   surrogate;
	logic                   emit;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [CXW-1:0]         count_ext;
	logic [CHARS_W-1:0]     chars_shown;

	logic s1_go;
	logic in_xfer;

	// handshakes: the input stage moves on whenever the result register can take its output
	assign s1_go        = !res_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || s1_go;
	assign in_xfer      = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	// bytes_left: 0 counts as 1, anything above 4 as 4
	always_comb begin
		unique case (left_s1)
			3'd0, 3'd1: left_n = 3'd1;
			3'd2:       left_n = 3'd2;
			3'd3:       left_n = 3'd3;
			default:    left_n = 3'd4;
		endcase
	end
	assign last = (left_n == 3'd1);

	// lead byte class and payload bits placed at their final position
	always_comb begin
		priority if (byte_s1[7] == 1'b0) begin
			lead_len = 3'd1;
			lead_cp  = {14'd0, byte_s1[6:0]};
		end else if (byte_s1[7:5] == 3'b110) begin
			lead_len = 3'd2;
			lead_cp  = {10'd0, byte_s1[4:0], 6'd0};
		end else if (byte_s1[7:4] == 4'b1110) begin
			lead_len = 3'd3;
			lead_cp  = {5'd0, byte_s1[3:0], 12'd0};
		end else if (byte_s1[7:3] == 5'b11110) begin
			lead_len = 3'd4;
			lead_cp  = {byte_s1[2:0], 18'd0};
		end else begin
			lead_len = 3'd0;
			lead_cp  = '0;
		end
	end

	assign cap_full = capacity_check_q && (CXW'(count_q) >= CXW'(capacity_q));

	// continuation payload placed by the number of bytes still to come after this one
	assign btc_dec = btc_q - 2'd1;
	always_comb begin
		unique case (btc_dec)
			2'd0:    cont_bits = {15'd0, byte_s1[5:0]};
			2'd1:    cont_bits = {9'd0, byte_s1[5:0], 6'd0};
			2'd2:    cont_bits = {3'd0, byte_s1[5:0], 12'd0};
			default: cont_bits = '0;
		endcase
	end

	// one decode step; checks in priority order
	always_comb begin
		status   = ST_OK;
		complete = 1'b0;
		btc_new  = btc_q;
		len_new  = len_q;
		cp_new   = partial_q;
		if (btc_q == 2'd0) begin
			priority if (cap_full) begin
				status = ST_CAPACITY;
			end else if (lead_len == 3'd0) begin
				status = ST_BAD_LEAD;
			end else if (lead_len > left_n) begin
				status = ST_TRUNCATED;
			end else begin
				len_new  = lead_len;
				btc_new  = 2'(lead_len - 3'd1);
				cp_new   = lead_cp;
				complete = (lead_len == 3'd1);
			end
		end else begin
			priority if (left_n < {1'b0, btc_q}) begin
				status = ST_TRUNCATED;
			end else if (byte_s1[7:6] != 2'b10) begin
				status = ST_BAD_CONT;
			end else begin
				btc_new  = btc_dec;
				cp_new   = partial_q | cont_bits;
				complete = (btc_dec == 2'd0);
			end
		end
		if (complete) begin
			priority if (!allow_overlong_q && overlong) begin
				status = ST_OVERLONG;
			end else if (!allow_surrogate_q && surrogate) begin
				status = ST_SURROGATE;
			end else begin
				status = ST_OK;
			end
		end
	end

	// final-byte checks on the assembled value
	always_comb begin
		unique case (len_new)
			3'd2:    overlong = (cp_new < MIN_TWO);
			3'd3:    overlong = (cp_new < MIN_THREE);
			3'd4:    overlong = (cp_new < MIN_FOUR);
			default: overlong = 1'b0;
		endcase
	end
	assign surrogate = (cp_new >= SURR_LO) && (cp_new <= SURR_HI);

	assign emit = !skip_q && ((status != ST_OK) || complete);

	// saturating char count, shown clipped to 16 bits
	assign count_next  = ((status == ST_OK) && (count_q != COUNT_MAX)) ?
		count_q + COUNT_WIDTH'(1) : count_q;
	assign count_ext   = CXW'(count_next);
	assign chars_shown = (count_ext > CXW'(CHARS_MAX)) ? CHARS_MAX : count_ext[CHARS_W-1:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_overlong_q  <= 1'b0;
			allow_surrogate_q <= 1'b0;
			capacity_check_q  <= 1'b0;
			capacity_q        <= CAP_RESET;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (reg_idx_t'(cfg_ch.reg_index))
				REG_ALLOW_OVERLONG:  allow_overlong_q  <= cfg_ch.wdata[0];
				REG_ALLOW_SURROGATE: allow_surrogate_q <= cfg_ch.wdata[0];
				REG_CAPACITY_CHECK:  capacity_check_q  <= cfg_ch.wdata[0];
				REG_CAPACITY:        capacity_q        <= cfg_ch.wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_ch.byte_value;
			left_s1 <= in_ch.bytes_left;
		end
	end

	// decode state, advanced once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btc_q     <= '0;
			len_q     <= '0;
			partial_q <= '0;
			count_q   <= '0;
			skip_q    <= 1'b0;
		end else if (valid_s1 && s1_go) begin
			if (skip_q) begin
				// swallowed byte; the last one reopens the stream
				if (last) begin
					skip_q  <= 1'b0;
					count_q <= '0;
				end
			end else if (!emit) begin
				btc_q     <= btc_new;
				len_q     <= len_new;
				partial_q <= cp_new;
			end else begin
				btc_q     <= '0;
				len_q     <= '0;
				partial_q <= '0;
				count_q   <= last ? '0 : count_next;
				skip_q    <= !last && (status != ST_OK);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go) begin
			res_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && valid_s1 && emit) begin
			res_has_cp_q <= (status == ST_OK);
			res_cp_q     <= (status == ST_OK) ? cp_new : '0;
			res_status_q <= status;
			res_done_q   <= (status != ST_OK) || last;
			res_chars_q  <= chars_shown;
		end
	end

	assign out_ch.valid         = res_valid_q;
	assign out_ch.has_codepoint = res_has_cp_q;
	assign out_ch.codepoint     = res_cp_q;
	assign out_ch.status        = res_status_q;
	assign out_ch.sequence_done = res_done_q;
	assign out_ch.chars_done    = res_chars_q;

	// a code point is carried exactly when the status is ok
	`ASSERT_IMPLY(a_cp_iff_ok, res_valid_q, res_has_cp_q == (res_status_q == ST_OK), "has_codepoint disagrees with status")
	// every error closes the sequence
	`ASSERT_IMPLY(a_err_done, res_valid_q && (res_status_q != ST_OK), res_done_q, "error result without sequence_done")
	// swallowing only happens with no character in progress
	`ASSERT_IMPLY(a_skip_idle, skip_q, (btc_q == 2'd0) && (partial_q == '0), "skip with a pending character")
	// pending continuation bytes never reach the character length
	`ASSERT_IMPLY(a_btc_len, btc_q != 2'd0, len_q > {1'b0, btc_q}, "pending count exceeds char length")

endmodule

`default_nettype wire
